FILE: sv/lcrsd_pkg.sv
package lcrsd_pkg;

  localparam int TARGET_W = 16;
  localparam int CUR_W    = 15;
  localparam int GAIN_W   = 16;
  localparam int SUPPLY_W = 13;
  localparam int DUTY_W   = 10;
  localparam int SETTLE_W = 7;
  localparam int THRESH_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // The product of current and gain, and the divisor supply * 256.
  localparam int PROD_W = CUR_W + GAIN_W;
  localparam int DEN_W  = SUPPLY_W + 8;
  localparam int STEP_W = $clog2(PROD_W);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1000);
  localparam logic signed [TARGET_W-1:0] TARGET_OFF_GATE = -16'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUX_THRESHOLD = 2'd0,
    REG_AUX_GAIN      = 2'd1,
    REG_MAIN_GAIN     = 2'd2,
    REG_SETTLE_DELAY  = 2'd3
  } cfg_reg_t;

endpackage

FILE: sv/led_current_range_select_dac_core.sv
// LED current range selector and PWM DAC duty generator. Each request is one
// control tick and yields exactly one result. A tick that holds or turns the
// LED off goes straight to the done state, and a tick with a zero supply takes
// full duty from the duty unit without dividing; a tick that recomputes the
// duty does one multiply of current by gain, then 31 restoring division steps
// through a single shared subtract-and-compare unit, then hands the duty over.
// The input stalls from acceptance until the result moves into the output
// register, so the next request can be accepted only once the block is idle
// again. A finished result may wait in the output register while the next
// request is already being worked on. Configuration writes are always ready.
module led_current_range_select_dac_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lcrsd_pkg::TARGET_W-1:0] target_current_ma,
  input  logic [lcrsd_pkg::SUPPLY_W-1:0]        supply_mv,
  input  logic                                  power_down,
  input  logic                                  strobe_mode,
  input  logic                                  pwm_upload_pending,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lcrsd_pkg::DUTY_W-1:0]          duty_permille,
  output logic                                  upload_request,
  output logic                                  rev_gate_on,
  output logic                                  converter_on,
  output logic                                  low_shunt_sel,
  output logic                                  high_shunt_sel,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcrsd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcrsd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lcrsd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [THRESH_W-1:0]         aux_threshold_ma;
  logic [GAIN_W-1:0]           aux_gain_q8;
  logic [GAIN_W-1:0]           main_gain_q8;
  logic [SETTLE_W-1:0]         settle_delay;

  logic signed [TARGET_W-1:0]  applied_current;
  logic [SETTLE_W-1:0]         settle_count;
  logic [DUTY_W-1:0]           duty_reg;
  logic                        gate_reg;
  logic                        converter_reg;
  logic                        low_sel_reg;
  logic                        high_sel_reg;
  logic                        upload;

  logic                        accept;
  logic signed [TARGET_W-1:0]  tgt;
  logic                        count_down;
  logic [SETTLE_W-1:0]         settle_count_next;
  logic                        converter_next;
  logic                        gate_next;
  logic                        low_sel_next;
  logic                        high_sel_next;
  logic                        upload_next;
  logic                        clear_duty;
  logic                        need_duty;
  logic [GAIN_W-1:0]           gain_sel;
  logic                        duty_done;
  logic [DUTY_W-1:0]           duty_result;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    tgt        = power_down ? '0 : target_current_ma;
    count_down = (settle_count != '0) && !pwm_upload_pending;
    settle_count_next = count_down ? settle_count - 1'b1 : settle_count;
    converter_next    = (count_down && settle_count == SETTLE_W'(1)) ? 1'b1 : converter_reg;
    gate_next     = gate_reg;
    low_sel_next  = low_sel_reg;
    high_sel_next = high_sel_reg;
    upload_next   = 1'b0;
    clear_duty    = 1'b0;
    need_duty     = 1'b0;
    gain_sel      = main_gain_q8;
    if (tgt != applied_current) begin
      if (tgt[TARGET_W-1] || tgt == '0) begin
        clear_duty     = !strobe_mode;
        upload_next    = !strobe_mode;
        gate_next      = (tgt == TARGET_OFF_GATE);
        converter_next = 1'b0;
        low_sel_next   = 1'b0;
        high_sel_next  = 1'b0;
      end else if (tgt[CUR_W-1:0] < aux_threshold_ma) begin
        need_duty     = 1'b1;
        upload_next   = 1'b1;
        gain_sel      = aux_gain_q8;
        gate_next     = 1'b0;
        low_sel_next  = 1'b1;
        high_sel_next = 1'b0;
        // The converter comes on later, when the settle count runs out.
        if (!converter_next) begin
          settle_count_next = settle_delay;
        end
      end else begin
        need_duty      = 1'b1;
        upload_next    = 1'b1;
        gate_next      = 1'b1;
        converter_next = 1'b1;
        low_sel_next   = 1'b0;
        high_sel_next  = 1'b1;
      end
    end
  end

  lcrsd_duty u_duty (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && need_duty),
    .current (tgt[CUR_W-1:0]),
    .gain    (gain_sel),
    .supply  (supply_mv),
    .done    (duty_done),
    .duty    (duty_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      aux_threshold_ma <= '0;
      aux_gain_q8      <= '0;
      main_gain_q8     <= '0;
      settle_delay     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AUX_THRESHOLD: aux_threshold_ma <= cfg_data[THRESH_W-1:0];
        REG_AUX_GAIN:      aux_gain_q8      <= cfg_data[GAIN_W-1:0];
        REG_MAIN_GAIN:     main_gain_q8     <= cfg_data[GAIN_W-1:0];
        REG_SETTLE_DELAY:  settle_delay     <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      applied_current <= '0;
      settle_count    <= '0;
      duty_reg        <= '0;
      gate_reg        <= 1'b0;
      converter_reg   <= 1'b0;
      low_sel_reg     <= 1'b0;
      high_sel_reg    <= 1'b0;
      upload          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            applied_current <= tgt;
            settle_count    <= settle_count_next;
            converter_reg   <= converter_next;
            gate_reg        <= gate_next;
            low_sel_reg     <= low_sel_next;
            high_sel_reg    <= high_sel_next;
            upload          <= upload_next;
            if (clear_duty) begin
              duty_reg <= '0;
            end
            state <= need_duty ? S_CALC : S_DONE;
          end
        end
        S_CALC: begin
          if (duty_done) begin
            duty_reg <= duty_result;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      duty_permille  <= duty_reg;
      upload_request <= upload;
      rev_gate_on    <= gate_reg;
      converter_on   <= converter_reg;
      low_shunt_sel  <= low_sel_reg;
      high_shunt_sel <= high_sel_reg;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request accepted while block still idle");

  a_one_shunt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(low_shunt_sel && high_shunt_sel))
    else $error("both shunt channels selected");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_permille <= DUTY_FULL))
    else $error("duty above full scale");

  a_main_channel_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && high_shunt_sel) |-> (rev_gate_on && converter_on))
    else $error("main channel selected without gate and converter");

endmodule

FILE: sv/lcrsd_duty.sv
module lcrsd_duty (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lcrsd_pkg::CUR_W-1:0]    current,
  input  logic [lcrsd_pkg::GAIN_W-1:0]   gain,
  input  logic [lcrsd_pkg::SUPPLY_W-1:0] supply,
  output logic                          done,
  output logic [lcrsd_pkg::DUTY_W-1:0]   duty
);
  import lcrsd_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } duty_state_t;

  duty_state_t        state;
  logic [CUR_W-1:0]   op_a;
  logic [GAIN_W-1:0]  op_b;
  logic [DEN_W-1:0]   den;
  logic [PROD_W-1:0]  quo;
  logic [DEN_W-1:0]   rem;
  logic [STEP_W-1:0]  step;

  // One restoring division step: shift in the next numerator bit and
  // subtract the divisor when it fits. The quotient replaces the numerator.
  logic [DEN_W:0]     rem_sh;
  logic [DEN_W+1:0]   diff;
  logic               fits;
  logic [DEN_W-1:0]   rem_next;
  logic [PROD_W-1:0]  quo_next;

  always_comb begin
    rem_sh   = {rem, quo[PROD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, den};
    fits     = !diff[DEN_W+1];
    rem_next = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_next = {quo[PROD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_IDLE && start && supply == '0) ||
              (state == D_DIV && step == STEP_W'(PROD_W - 1));
      case (state)
        D_IDLE: begin
          if (start) begin
            if (supply == '0) begin
              duty <= DUTY_FULL;
            end else begin
              state <= D_MUL;
            end
          end
        end
        D_MUL: begin
          state <= D_DIV;
        end
        D_DIV: begin
          if (step == STEP_W'(PROD_W - 1)) begin
            duty  <= (quo_next > PROD_W'(DUTY_FULL)) ? DUTY_FULL : quo_next[DUTY_W-1:0];
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        op_a <= current;
        op_b <= gain;
        den  <= {supply, 8'h00};
      end
      D_MUL: begin
        quo  <= op_a * op_b;
        rem  <= '0;
        step <= '0;
      end
      D_DIV: begin
        quo  <= quo_next;
        rem  <= rem_next;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: bench/led_current_range_select_dac_core_tb.sv
`timescale 1ns / 1ps

module led_current_range_select_dac_core_tb;
  import lcrsd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [TARGET_W-1:0] target;
    logic [SUPPLY_W-1:0]        supply;
    logic                       pdown;
    logic                       strobe;
    logic                       pending;
  } dac_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              upload;
    logic              gate;
    logic              conv;
    logic              low_sel;
    logic              high_sel;
  } dac_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [TARGET_W-1:0] target_current_ma = '0;
  logic [SUPPLY_W-1:0]        supply_mv = '0;
  logic                       power_down = 1'b0;
  logic                       strobe_mode = 1'b0;
  logic                       pwm_upload_pending = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [DUTY_W-1:0]          duty_permille;
  logic                       upload_request;
  logic                       rev_gate_on;
  logic                       converter_on;
  logic                       low_shunt_sel;
  logic                       high_shunt_sel;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  led_current_range_select_dac_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_current_ma(target_current_ma), .supply_mv(supply_mv),
    .power_down(power_down), .strobe_mode(strobe_mode),
    .pwm_upload_pending(pwm_upload_pending),
    .out_valid(out_valid), .out_stall(out_stall),
    .duty_permille(duty_permille), .upload_request(upload_request),
    .rev_gate_on(rev_gate_on), .converter_on(converter_on),
    .low_shunt_sel(low_shunt_sel), .high_shunt_sel(high_shunt_sel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: configuration and tick state.
  logic [THRESH_W-1:0]        thr_sh;
  logic [GAIN_W-1:0]          aux_gain_sh;
  logic [GAIN_W-1:0]          main_gain_sh;
  logic [SETTLE_W-1:0]        delay_sh;
  logic signed [TARGET_W-1:0] applied_cur;
  logic [SETTLE_W-1:0]        settle_cnt;
  logic [DUTY_W-1:0]          duty_q;
  logic                       gate_q, conv_q, low_q, high_q;

  dac_req_t pending_reqs[$];
  dac_out_t expected_ticks[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_held = 0, n_off = 0, n_low = 0, n_high = 0;
  int n_phases = 0;
  int cyc = 0;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic calm = 1'b0;
  logic rx_hold_go = 1'b0;
  logic rx_hold_seen = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic signed [TARGET_W-1:0] gen_last = '0;

  function automatic logic [DUTY_W-1:0] duty_for(input logic [CUR_W-1:0] cur,
                                                 input logic [GAIN_W-1:0] gain,
                                                 input logic [SUPPLY_W-1:0] sup);
    longint unsigned q;
    if (sup == 0) return DUTY_FULL;
    q = (64'(cur) * 64'(gain)) / (64'(sup) * 64'd256);
    if (q > 64'(DUTY_FULL)) return DUTY_FULL;
    return q[DUTY_W-1:0];
  endfunction

  function automatic dac_out_t dac_tick(input dac_req_t r);
    logic signed [TARGET_W-1:0] tgt;
    dac_out_t o;
    o.upload = 1'b0;
    // The settle count only runs while no duty upload is outstanding.
    if (settle_cnt != 0 && !r.pending) begin
      settle_cnt = settle_cnt - 1'b1;
      if (settle_cnt == 0) conv_q = 1'b1;
    end
    tgt = r.pdown ? '0 : r.target;
    if (tgt == applied_cur) begin
      n_held++;
    end else begin
      applied_cur = tgt;
      if (tgt <= 0) begin
        if (!r.strobe) begin
          duty_q = '0;
          o.upload = 1'b1;
        end
        gate_q = (tgt == TARGET_OFF_GATE);
        conv_q = 1'b0;
        low_q = 1'b0;
        high_q = 1'b0;
        n_off++;
      end else if (tgt[CUR_W-1:0] < thr_sh) begin
        duty_q = duty_for(tgt[CUR_W-1:0], aux_gain_sh, r.supply);
        gate_q = 1'b0;
        if (!conv_q) settle_cnt = delay_sh;
        low_q = 1'b1;
        high_q = 1'b0;
        o.upload = 1'b1;
        n_low++;
      end else begin
        duty_q = duty_for(tgt[CUR_W-1:0], main_gain_sh, r.supply);
        gate_q = 1'b1;
        conv_q = 1'b1;
        low_q = 1'b0;
        high_q = 1'b1;
        o.upload = 1'b1;
        n_high++;
      end
    end
    o.duty = duty_q;
    o.gate = gate_q;
    o.conv = conv_q;
    o.low_sel = low_q;
    o.high_sel = high_q;
    return o;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (calm) return 0;
    sel = $urandom_range(99, 0);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(3, 1);
    if (sel < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic [SUPPLY_W-1:0] pick_supply();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 5) return '0;
    if (sel < 35) return SUPPLY_W'($urandom_range(255, 1));
    return SUPPLY_W'($urandom);
  endfunction

  always @(posedge clk) begin : scoreboard
    dac_out_t want;
    if (rst) begin
      thr_sh = '0;
      aux_gain_sh = '0;
      main_gain_sh = '0;
      delay_sh = '0;
      applied_cur = '0;
      settle_cnt = '0;
      duty_q = '0;
      gate_q = 1'b0;
      conv_q = 1'b0;
      low_q = 1'b0;
      high_q = 1'b0;
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_AUX_THRESHOLD: thr_sh = cfg_data[THRESH_W-1:0];
          REG_AUX_GAIN:      aux_gain_sh = cfg_data[GAIN_W-1:0];
          REG_MAIN_GAIN:     main_gain_sh = cfg_data[GAIN_W-1:0];
          REG_SETTLE_DELAY:  delay_sh = cfg_data[SETTLE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $error("result delivered with no request outstanding");
          n_err++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("duty_permille", want.duty, duty_permille);
          check_field("upload_request", want.upload, upload_request);
          check_field("rev_gate_on", want.gate, rev_gate_on);
          check_field("converter_on", want.conv, converter_on);
          check_field("low_shunt_sel", want.low_sel, low_shunt_sel);
          check_field("high_shunt_sel", want.high_sel, high_shunt_sel);
        end
        n_checked <= n_checked + 1;
      end
      if (in_valid && !in_stall) begin
        expected_ticks.push_back(dac_tick('{target_current_ma, supply_mv, power_down,
                                            strobe_mode, pwm_upload_pending}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  always @(negedge clk) begin : request_driver
    dac_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        target_current_ma <= r.target;
        supply_mv <= r.supply;
        power_down <= r.pdown;
        strobe_mode <= r.strobe;
        pwm_upload_pending <= r.pending;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end
    end
  end

  always @(negedge clk) begin : result_stall
    int unsigned g;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_hold_go && !rx_hold_seen) begin
      // One long hold-off so the block backs up and stalls its input.
      rx_hold_seen <= 1'b1;
      out_stall <= 1'b1;
      stall_left <= 399;
    end else begin
      g = pick_gap();
      out_stall <= (g != 0);
      stall_left <= (g == 0) ? 0 : g - 1;
    end
  end

  initial begin : watchdog
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("led_current_range_select_dac_core_tb: done, errors");
    $finish;
  end

  task automatic put(input logic signed [TARGET_W-1:0] tgt, input logic [SUPPLY_W-1:0] sup,
                     input logic pd, input logic st, input logic pend);
    pending_reqs.push_back('{tgt, sup, pd, st, pend});
    gen_last = pd ? '0 : tgt;
    n_queued++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic program_regs(input logic [THRESH_W-1:0] thr, input logic [GAIN_W-1:0] ag,
                              input logic [GAIN_W-1:0] mg, input logic [SETTLE_W-1:0] dly);
    write_reg(REG_AUX_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_AUX_GAIN, ag);
    write_reg(REG_MAIN_GAIN, mg);
    write_reg(REG_SETTLE_DELAY, CFG_DATA_W'(dly));
    cfg_valid = 1'b0;
    n_phases++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_checked != n_queued);
  endtask

  // One new target, then a run of repeats so the settle count gets to play out.
  task automatic add_episode(input int thr, input int dly);
    int unsigned sel;
    int unsigned n_rep;
    logic signed [TARGET_W-1:0] tgt;
    sel = $urandom_range(99, 0);
    if (sel < 12) tgt = TARGET_OFF_GATE;
    else if (sel < 17) tgt = '0;
    else if (sel < 22) tgt = TARGET_W'(-1 - int'($urandom_range(32767, 1)));
    else if (sel < 55) tgt = TARGET_W'((thr > 1) ? $urandom_range(thr - 1, 1) : 1);
    else if (sel < 63) tgt = TARGET_W'(thr);
    else if (sel < 90) tgt = TARGET_W'($urandom_range(32767, thr));
    else tgt = TARGET_W'($urandom);
    put(tgt, pick_supply(), $urandom_range(19, 0) == 0, $urandom_range(3, 0) == 0,
        $urandom_range(9, 0) < 4);
    sel = $urandom_range(9, 0);
    if (sel < 5) n_rep = $urandom_range(3, 0);
    else if (sel < 8) n_rep = $urandom_range(12, 4);
    else n_rep = dly + $urandom_range(4, 0);
    repeat (n_rep)
      put(gen_last, pick_supply(), 1'b0, $urandom_range(3, 0) == 0, $urandom_range(9, 0) < 4);
  endtask

  initial begin : stimulus
    logic [THRESH_W-1:0] thr;
    logic [GAIN_W-1:0]   ag, mg;
    logic [SETTLE_W-1:0] dly;
    int                  stop_at;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    program_regs(15'd1000, 16'h4000, 16'h9000, 7'd3);
    @(posedge clk);
    put(16'sd0, 13'd100, 1'b0, 1'b0, 1'b0);       // matches the reset current: holds
    put(-16'sd1, 13'd100, 1'b0, 1'b0, 1'b0);      // off with the gate on
    put(-16'sd1, 13'd8191, 1'b0, 1'b0, 1'b0);
    put(-16'sd32768, 13'd0, 1'b0, 1'b0, 1'b0);    // other negative: gate off
    put(16'sd500, 13'd1, 1'b0, 1'b0, 1'b0);       // low range, duty clamps, settle loads
    put(16'sd500, 13'd50, 1'b0, 1'b0, 1'b1);      // pending upload freezes the count
    put(16'sd500, 13'd50, 1'b0, 1'b0, 1'b0);
    put(16'sd500, 13'd8191, 1'b0, 1'b0, 1'b0);
    put(16'sd500, 13'd8191, 1'b0, 1'b0, 1'b0);    // count expires, converter on
    put(16'sd999, 13'd8191, 1'b0, 1'b0, 1'b0);    // converter already on: no reload
    put(16'sd1000, 13'd8191, 1'b0, 1'b0, 1'b0);   // at the threshold: main range
    put(16'sd32767, 13'd8191, 1'b0, 1'b0, 1'b0);
    put(16'sd32767, 13'd0, 1'b1, 1'b0, 1'b0);     // power down forces zero
    put(16'sd200, 13'd0, 1'b0, 1'b0, 1'b0);       // zero supply gives full duty
    put(-16'sd1, 13'd100, 1'b0, 1'b1, 1'b0);      // strobe keeps the duty
    put(-16'sd1, 13'd100, 1'b0, 1'b0, 1'b0);
    put(-16'sd1, 13'd100, 1'b0, 1'b0, 1'b0);      // count still expires while off
    put(16'sd0, 13'd100, 1'b0, 1'b1, 1'b0);
    put(16'sd1, 13'd8191, 1'b0, 1'b0, 1'b0);
    put(16'sd1, 13'd8191, 1'b0, 1'b0, 1'b1);
    put(16'sd12345, 13'd4095, 1'b0, 1'b0, 1'b0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin thr = '1; ag = '1; mg = '1; dly = '1; end
        1: begin thr = '0; ag = '0; mg = '0; dly = '0; end
        2: begin thr = 15'd1; ag = 16'd1; mg = 16'd1; dly = 7'd1; end
        3: begin
          thr = THRESH_W'($urandom);
          ag = GAIN_W'($urandom);
          mg = GAIN_W'($urandom);
          dly = '0;
        end
        default: begin
          thr = THRESH_W'($urandom_range(4000, 1));
          ag = GAIN_W'($urandom);
          mg = GAIN_W'($urandom);
          dly = SETTLE_W'($urandom_range(20, 1));
        end
      endcase
      program_regs(thr, ag, mg, dly);
      calm <= (p % 3 == 2);
      @(posedge clk);
      stop_at = n_queued + 250;
      while (n_queued < stop_at) add_episode(int'(thr), int'(dly));
      if (p == 0) rx_hold_go <= 1'b1;
      wait_idle();
    end

    repeat (60) @(negedge clk);
    if (expected_ticks.size() != 0) begin
      $error("%0d results never arrived", expected_ticks.size());
      n_err++;
    end
    $display("Ran %0d ticks over %0d register settings, %0d results checked.",
             n_accepted, n_phases, n_checked);
    $display("Ticks: %0d held, %0d off, %0d low range, %0d main range.",
             n_held, n_off, n_low, n_high);
    if (n_err == 0)
      $display("led_current_range_select_dac_core_tb: done, clean");
    else
      $display("led_current_range_select_dac_core_tb: done, errors");
    $finish;
  end

endmodule
